[src/bose_pkg.sv]
// shared constants, types and helpers of the box outline segment emitter
`default_nettype none

package bose_pkg;

  localparam int SCREEN_WIDTH_DEF  = 480;
  localparam int SCREEN_HEIGHT_DEF = 272;
  localparam int MAX_THICKNESS_DEF = 8;

  localparam int COORD_IN_W  = 16;
  localparam int COORD_OUT_W = 9;
  localparam int COLOR_W     = 16;
  localparam int CLASS_W     = 8;
  localparam int ARGB_W      = 32;
  localparam int THICK_W     = 8;

  localparam int QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ARGB     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LINE_THICKNESS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_COLOR_ZERO = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_COLOR_ONE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLASS_COLOR_TWO  = 3'd4;

  localparam logic [ARGB_W-1:0]  DEFAULT_ARGB_RST     = 32'hFF00_FF00;
  localparam logic [THICK_W-1:0] LINE_THICKNESS_RST   = 8'd1;
  localparam logic [COLOR_W-1:0] CLASS_COLOR_ZERO_RST = 16'hFFE0;
  localparam logic [COLOR_W-1:0] CLASS_COLOR_ONE_RST  = 16'h07E0;
  localparam logic [COLOR_W-1:0] CLASS_COLOR_TWO_RST  = 16'hF81F;

  localparam logic [CLASS_W-1:0] CLASS_ZERO = 8'd0;
  localparam logic [CLASS_W-1:0] CLASS_ONE  = 8'd1;
  localparam logic [CLASS_W-1:0] CLASS_TWO  = 8'd2;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  typedef struct packed {
    logic [ARGB_W-1:0]  default_argb;
    logic [THICK_W-1:0] line_thickness;
    logic [COLOR_W-1:0] class_color_zero;
    logic [COLOR_W-1:0] class_color_one;
    logic [COLOR_W-1:0] class_color_two;
  } cfg_t;

  function automatic logic [COLOR_W-1:0] argb_to_rgb565(input logic [ARGB_W-1:0] argb);
    return {argb[23:19], argb[15:10], argb[7:3]};
  endfunction

endpackage

`default_nettype wire

[src/bose_regs.sv]
// configuration register file with apb-style access
`default_nettype none

module bose_regs
  import bose_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_argb     <= DEFAULT_ARGB_RST;
      cfg.line_thickness   <= LINE_THICKNESS_RST;
      cfg.class_color_zero <= CLASS_COLOR_ZERO_RST;
      cfg.class_color_one  <= CLASS_COLOR_ONE_RST;
      cfg.class_color_two  <= CLASS_COLOR_TWO_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DEFAULT_ARGB:     cfg.default_argb     <= pwdata[ARGB_W-1:0];
        REG_LINE_THICKNESS:   cfg.line_thickness   <= pwdata[THICK_W-1:0];
        REG_CLASS_COLOR_ZERO: cfg.class_color_zero <= pwdata[COLOR_W-1:0];
        REG_CLASS_COLOR_ONE:  cfg.class_color_one  <= pwdata[COLOR_W-1:0];
        REG_CLASS_COLOR_TWO:  cfg.class_color_two  <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEFAULT_ARGB:     prdata = APB_DATA_W'(cfg.default_argb);
      REG_LINE_THICKNESS:   prdata = APB_DATA_W'(cfg.line_thickness);
      REG_CLASS_COLOR_ZERO: prdata = APB_DATA_W'(cfg.class_color_zero);
      REG_CLASS_COLOR_ONE:  prdata = APB_DATA_W'(cfg.class_color_one);
      REG_CLASS_COLOR_TWO:  prdata = APB_DATA_W'(cfg.class_color_two);
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/bose_front.sv]
// front end: clamps a box, drops degenerate ones, picks color and per-side step counts
`default_nettype none

module bose_front
  import bose_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEF,
  localparam int CW    = $clog2(SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT),
  localparam int TW    = $clog2(MAX_THICKNESS + 1),
  localparam int JOB_W = 4 * CW + COLOR_W + 4 * TW
)
(
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_IN_W-1:0] box_left,
  input  wire logic signed [COORD_IN_W-1:0] box_top,
  input  wire logic signed [COORD_IN_W-1:0] box_right,
  input  wire logic signed [COORD_IN_W-1:0] box_bottom,
  input  wire logic        [CLASS_W-1:0]    box_class,
  input  wire cfg_t                         cfg,
  input  wire logic                         q_full,
  output logic                              q_push,
  output logic             [JOB_W-1:0]      q_data
);

  localparam int LW = CW + 1;

  typedef struct packed {
    logic [CW-1:0]      x1;
    logic [CW-1:0]      x2;
    logic [CW-1:0]      y1;
    logic [CW-1:0]      y2;
    logic [COLOR_W-1:0] color;
    logic [TW-1:0]      c_top;
    logic [TW-1:0]      c_bot;
    logic [TW-1:0]      c_left;
    logic [TW-1:0]      c_right;
  } job_t;

  function automatic logic [CW-1:0] clamp_coord(input logic signed [COORD_IN_W-1:0] v,
                                                input int lim);
    logic [CW-1:0] r;
    if (v[COORD_IN_W-1]) begin
      r = '0;
    end else if (v[COORD_IN_W-2:0] > (COORD_IN_W-1)'(lim - 1)) begin
      r = CW'(lim - 1);
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  logic [TW-1:0] th;
  logic [LW-1:0] lim_top;
  logic [LW-1:0] lim_bot;
  logic [LW-1:0] lim_left;
  logic [LW-1:0] lim_right;
  logic          degenerate;
  job_t          job;

  function automatic logic [TW-1:0] step_count(input logic [TW-1:0] t_max,
                                               input logic [LW-1:0] lim);
    return (LW'(t_max) < lim) ? t_max : TW'(lim);
  endfunction

  always_comb begin
    priority if (cfg.line_thickness == '0) begin
      th = TW'(1);
    end else if (cfg.line_thickness > THICK_W'(MAX_THICKNESS)) begin
      th = TW'(MAX_THICKNESS);
    end else begin
      th = TW'(cfg.line_thickness);
    end
  end

  always_comb begin
    job.x1 = clamp_coord(box_left, SCREEN_WIDTH);
    job.x2 = clamp_coord(box_right, SCREEN_WIDTH);
    job.y1 = clamp_coord(box_top, SCREEN_HEIGHT);
    job.y2 = clamp_coord(box_bottom, SCREEN_HEIGHT);

    unique case (box_class)
      CLASS_ZERO: job.color = cfg.class_color_zero;
      CLASS_ONE:  job.color = cfg.class_color_one;
      CLASS_TWO:  job.color = cfg.class_color_two;
      default:    job.color = argb_to_rgb565(cfg.default_argb);
    endcase

    lim_top   = LW'(SCREEN_HEIGHT) - {1'b0, job.y1};
    lim_bot   = {1'b0, job.y2} + LW'(1);
    lim_left  = LW'(SCREEN_WIDTH) - {1'b0, job.x1};
    lim_right = {1'b0, job.x2} + LW'(1);

    job.c_top   = step_count(th, lim_top);
    job.c_bot   = step_count(th, lim_bot);
    job.c_left  = step_count(th, lim_left);
    job.c_right = step_count(th, lim_right);
  end

  assign degenerate = (job.x2 <= job.x1) || (job.y2 <= job.y1);
  assign in_ready   = !q_full;
  assign q_push     = in_valid && in_ready && !degenerate;
  assign q_data     = job;

endmodule

`default_nettype wire

[src/bose_queue.sv]
// short job queue between front and back end
`default_nettype none

module bose_queue
  import bose_pkg::*;
#(
  parameter int WIDTH = 1
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/bose_back.sv]
// back end: walks thickness steps and sides, emits at most one segment per cycle while the output does not stall
`default_nettype none

module bose_back
  import bose_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEF,
  localparam int CW    = $clog2(SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT),
  localparam int TW    = $clog2(MAX_THICKNESS + 1),
  localparam int JOB_W = 4 * CW + COLOR_W + 4 * TW
)
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_empty,
  input  wire logic [JOB_W-1:0]       q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        segment_vertical,
  output logic      [COORD_OUT_W-1:0] x_start,
  output logic      [COORD_OUT_W-1:0] x_end,
  output logic      [COORD_OUT_W-1:0] y_start,
  output logic      [COORD_OUT_W-1:0] y_end,
  output logic      [COLOR_W-1:0]     segment_color,
  output logic                        last_segment
);

  typedef struct packed {
    logic [CW-1:0]      x1;
    logic [CW-1:0]      x2;
    logic [CW-1:0]      y1;
    logic [CW-1:0]      y2;
    logic [COLOR_W-1:0] color;
    logic [TW-1:0]      c_top;
    logic [TW-1:0]      c_bot;
    logic [TW-1:0]      c_left;
    logic [TW-1:0]      c_right;
  } job_t;

  job_t          job;
  logic          busy;
  logic [TW-1:0] t;
  logic [1:0]    side;

  logic [TW-1:0] c_cur;
  logic [TW-1:0] t_inc;
  logic [CW-1:0] t_c;
  logic          seg_ok;
  logic          no_later_step;
  logic          no_later_side;
  logic          is_last;
  logic          out_free;
  logic          step;
  logic          done;
  logic          load;

  logic          seg_vert;
  logic [CW-1:0] seg_xs;
  logic [CW-1:0] seg_xe;
  logic [CW-1:0] seg_ys;
  logic [CW-1:0] seg_ye;

  assign t_inc = t + TW'(1);
  assign t_c   = CW'(t);

  always_comb begin
    unique case (side)
      SIDE_TOP: begin
        c_cur         = job.c_top;
        no_later_side = (job.c_bot <= t) && (job.c_left <= t) && (job.c_right <= t);
        seg_vert      = 1'b0;
        seg_xs        = job.x1;
        seg_xe        = job.x2;
        seg_ys        = job.y1 + t_c;
        seg_ye        = job.y1 + t_c;
      end
      SIDE_BOTTOM: begin
        c_cur         = job.c_bot;
        no_later_side = (job.c_left <= t) && (job.c_right <= t);
        seg_vert      = 1'b0;
        seg_xs        = job.x1;
        seg_xe        = job.x2;
        seg_ys        = job.y2 - t_c;
        seg_ye        = job.y2 - t_c;
      end
      SIDE_LEFT: begin
        c_cur         = job.c_left;
        no_later_side = (job.c_right <= t);
        seg_vert      = 1'b1;
        seg_xs        = job.x1 + t_c;
        seg_xe        = job.x1 + t_c;
        seg_ys        = job.y1;
        seg_ye        = job.y2;
      end
      SIDE_RIGHT: begin
        c_cur         = job.c_right;
        no_later_side = 1'b1;
        seg_vert      = 1'b1;
        seg_xs        = job.x2 - t_c;
        seg_xe        = job.x2 - t_c;
        seg_ys        = job.y1;
        seg_ye        = job.y2;
      end
      default: begin
        c_cur         = '0;
        no_later_side = 1'b1;
        seg_vert      = 1'b0;
        seg_xs        = '0;
        seg_xe        = '0;
        seg_ys        = '0;
        seg_ye        = '0;
      end
    endcase
  end

  assign no_later_step = (job.c_top <= t_inc) && (job.c_bot <= t_inc) &&
                         (job.c_left <= t_inc) && (job.c_right <= t_inc);
  assign is_last  = no_later_step && no_later_side;
  assign seg_ok   = busy && (t < c_cur);
  assign out_free = !out_valid || out_ready;
  assign step     = busy && (!seg_ok || out_free);
  assign done     = step && seg_ok && is_last;
  assign load     = (!busy || done) && !q_empty;
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      t         <= '0;
      side      <= SIDE_TOP;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        t    <= '0;
        side <= SIDE_TOP;
      end else if (done) begin
        busy <= 1'b0;
      end else if (step) begin
        if (side == SIDE_RIGHT) begin
          side <= SIDE_TOP;
          t    <= t_inc;
        end else begin
          side <= side + 2'd1;
        end
      end

      if (step && seg_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= q_data;
    end
    if (step && seg_ok) begin
      segment_vertical <= seg_vert;
      x_start          <= COORD_OUT_W'(seg_xs);
      x_end            <= COORD_OUT_W'(seg_xe);
      y_start          <= COORD_OUT_W'(seg_ys);
      y_end            <= COORD_OUT_W'(seg_ye);
      segment_color    <= job.color;
      last_segment     <= is_last;
    end
  end

endmodule

`default_nettype wire

[src/box_outline_segment_emitter.sv]
// top level of the box outline segment emitter
`default_nettype none

// Takes one detection box per transaction, clamps it to the screen and emits its outline
// as row and column fill segments, one segment per transaction on the output. The front
// end classifies a box in the cycle it is taken and accepts a new box every cycle while
// the two-entry job queue has room; boxes with no area after clamping are accepted and
// produce nothing. The back end walks four side positions per thickness step, one
// position per cycle while the output does not stall, and stops at the final segment;
// the thickness is clamped to the maximum, with a default maximum of eight. Off-screen
// positions before the final segment are walked too and produce no segment. The final
// segment of each box carries last_segment.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16.

module box_outline_segment_emitter
  import bose_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
)
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic        [APB_ADDR_W-1:0] paddr,
  input  wire logic        [APB_DATA_W-1:0] pwdata,
  output logic             [APB_DATA_W-1:0] prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_IN_W-1:0] box_left,
  input  wire logic signed [COORD_IN_W-1:0] box_top,
  input  wire logic signed [COORD_IN_W-1:0] box_right,
  input  wire logic signed [COORD_IN_W-1:0] box_bottom,
  input  wire logic        [CLASS_W-1:0]    box_class,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              segment_vertical,
  output logic             [COORD_OUT_W-1:0] x_start,
  output logic             [COORD_OUT_W-1:0] x_end,
  output logic             [COORD_OUT_W-1:0] y_start,
  output logic             [COORD_OUT_W-1:0] y_end,
  output logic             [COLOR_W-1:0]    segment_color,
  output logic                              last_segment
);

  localparam int CW    = $clog2(SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT);
  localparam int TW    = $clog2(MAX_THICKNESS + 1);
  localparam int JOB_W = 4 * CW + COLOR_W + 4 * TW;

  cfg_t             cfg;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [JOB_W-1:0] q_wdata;
  logic [JOB_W-1:0] q_rdata;

  bose_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bose_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom),
    .box_class  (box_class),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  bose_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bose_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .segment_vertical (segment_vertical),
    .x_start          (x_start),
    .x_end            (x_end),
    .y_start          (y_start),
    .y_end            (y_end),
    .segment_color    (segment_color),
    .last_segment     (last_segment)
  );

endmodule

`default_nettype wire

[src/bose_port_checker.sv]
// port-level checker for the box outline segment emitter, bound to the top level
`default_nettype none

module bose_port_checker
  import bose_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   segment_vertical,
  input wire logic [COORD_OUT_W-1:0] x_start,
  input wire logic [COORD_OUT_W-1:0] x_end,
  input wire logic [COORD_OUT_W-1:0] y_start,
  input wire logic [COORD_OUT_W-1:0] y_end,
  input wire logic [COLOR_W-1:0]     segment_color,
  input wire logic                   last_segment
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({segment_vertical, x_start, x_end, y_start, y_end, segment_color, last_segment}))
    else $error("output transaction changed while stalled");

  a_row_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !segment_vertical |-> (y_start == y_end) && (x_start < x_end))
    else $error("row segment with bad extent");

  a_col_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_vertical |-> (x_start == x_end) && (y_start < y_end))
    else $error("column segment with bad extent");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind box_outline_segment_emitter bose_port_checker u_port_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .segment_vertical (segment_vertical),
  .x_start          (x_start),
  .x_end            (x_end),
  .y_start          (y_start),
  .y_end            (y_end),
  .segment_color    (segment_color),
  .last_segment     (last_segment)
);

`default_nettype wire
